>>> hdl/qpc_pkg.sv
// Shared types, reset values and a helper function of the quadrature position counter.
package qpc_pkg;

    localparam int unsigned POS_W  = 32;
    localparam int unsigned STEP_W = 16;

    localparam logic [STEP_W-1:0] STEP_SIZE_RESET      = 16'd655;
    localparam logic [POS_W-1:0]  START_POSITION_RESET = '0;

    // Configuration register indexes.
    typedef enum logic {
        CFG_STEP_SIZE      = 1'b0,
        CFG_START_POSITION = 1'b1
    } cfg_index_t;

    // Phase of the decoder: four channel levels and two pending-count states.
    typedef enum logic [5:0] {
        PH_LOW  = 6'b000001,
        PH_ATBF = 6'b000010,
        PH_HIGH = 6'b000100,
        PH_AFBT = 6'b001000,
        PH_CW   = 6'b010000,
        PH_CCW  = 6'b100000
    } phase_t;

    // Count decision passed from the phase tracker to the position datapath.
    typedef struct packed {
        logic cw;
        logic ccw;
    } count_t;

    function automatic phase_t level_code(input logic a, input logic b);
        phase_t lv;
        if (a && b) begin
            lv = PH_HIGH;
        end else if (a) begin
            lv = PH_ATBF;
        end else if (b) begin
            lv = PH_AFBT;
        end else begin
            lv = PH_LOW;
        end
        return lv;
    endfunction

endpackage

>>> hdl/qpc_phase.sv
// Phase tracker of the quadrature position counter: edge detection and count decision.
module qpc_phase
    import qpc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   accept,
    input  logic   load,
    input  logic   chan_a,
    input  logic   chan_b,
    output count_t count
);

    phase_t phase_reg;
    phase_t phase_next;
    phase_t lv;

    assign lv = level_code(chan_a, chan_b);

    always_comb begin
        phase_next = phase_reg;
        count      = '0;
        if (load) begin
            phase_next = lv;
        end else begin
            unique case (phase_reg)
                PH_LOW: begin
                    if (lv == PH_ATBF) phase_next = PH_CW;
                    else if (lv == PH_AFBT) phase_next = PH_CCW;
                end
                PH_ATBF: begin
                    if (lv == PH_HIGH) phase_next = PH_CW;
                    else if (lv == PH_LOW) phase_next = PH_CCW;
                end
                PH_HIGH: begin
                    if (lv == PH_AFBT) phase_next = PH_CW;
                    else if (lv == PH_ATBF) phase_next = PH_CCW;
                end
                PH_AFBT: begin
                    if (lv == PH_LOW) phase_next = PH_CW;
                    else if (lv == PH_HIGH) phase_next = PH_CCW;
                end
                // The pending count lands now, and the phase is taken straight
                // from the channels, so a change in this transfer is not counted.
                PH_CW: begin
                    count.cw   = 1'b1;
                    phase_next = lv;
                end
                PH_CCW: begin
                    count.ccw  = 1'b1;
                    phase_next = lv;
                end
                default: begin
                    phase_next = lv;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LOW;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
    end

    a_level_after_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !load && (phase_reg == PH_CW || phase_reg == PH_CCW)
        |=> phase_reg != PH_CW && phase_reg != PH_CCW)
        else $error("phase still pending after a count landed");

    a_load_takes_level: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && load |=> phase_reg == level_code($past(chan_a), $past(chan_b)))
        else $error("load did not take the phase from the channels");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(phase_reg))
        else $error("phase moved without an input transfer");

endmodule

>>> hdl/quadrature_position_counter_core.sv
// Top level of the quadrature position counter: handshakes, configuration and position.
//
// x4 quadrature decoder with a saturating signed Q16.16 position. Each input
// transfer carries one sample of channels A and B (and a load flag) and yields
// exactly one result, the position after that sample. The Gray order
// 00,10,11,01 (A then B) counts clockwise by step_size; a count lands on the
// transfer after its edge, and a change of the channels on that transfer is
// not counted. A load sets the position to start_position and takes the phase
// from A,B. One input transfer is accepted per clock cycle while the output
// register is free or being read; its result appears there on the next cycle,
// and a new sample is taken while that result is being transferred. The count
// decision and 33-bit saturating add feed the output register. Configuration
// writes are always accepted (cfg_ready is high): index 0 is step_size, index
// 1 is start_position; write them only while no result is outstanding.
module quadrature_position_counter_core
    import qpc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_load,
    input  logic                     s_chan_a,
    input  logic                     s_chan_b,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [POS_W-1:0]  m_position,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  cfg_index_t               cfg_index,
    input  logic [POS_W-1:0]         cfg_data
);

    logic [STEP_W-1:0]        step_size_reg;
    logic signed [POS_W-1:0]  start_position_reg;
    logic signed [POS_W-1:0]  accum_reg;
    logic signed [POS_W-1:0]  accum_next;
    logic                     m_valid_reg;
    logic                     s_accept;
    count_t                   count;
    logic signed [POS_W:0]    delta;
    logic signed [POS_W:0]    sum;

    assign cfg_ready  = 1'b1;
    assign s_ready    = !m_valid_reg || m_ready;
    assign s_accept   = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_position = accum_reg;

    qpc_phase u_phase (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .load    (s_load),
        .chan_a  (s_chan_a),
        .chan_b  (s_chan_b),
        .count   (count)
    );

    always_comb begin
        delta = $signed({{(POS_W + 1 - STEP_W){1'b0}}, step_size_reg});
        if (count.ccw) begin
            delta = -delta;
        end
        sum = $signed({accum_reg[POS_W-1], accum_reg}) + delta;
        priority if (s_load) begin
            accum_next = start_position_reg;
        end else if (count.cw || count.ccw) begin
            // The two top bits of the sum differ only when it left the 32-bit range.
            if (sum[POS_W] != sum[POS_W-1]) begin
                accum_next = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                        : {1'b0, {(POS_W-1){1'b1}}};
            end else begin
                accum_next = sum[POS_W-1:0];
            end
        end else begin
            accum_next = accum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg      <= STEP_SIZE_RESET;
            start_position_reg <= START_POSITION_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_STEP_SIZE:      step_size_reg      <= cfg_data[STEP_W-1:0];
                CFG_START_POSITION: start_position_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                accum_reg <= accum_next;
            end
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    a_load_sets_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_load |=> m_position == $past(start_position_reg))
        else $error("load transfer did not give the start position");

    a_no_count_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_load && !count.cw && !count.ccw |=> $stable(m_position))
        else $error("position changed on a transfer without a count");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(m_position))
        else $error("position changed without an input transfer");

endmodule

>>> tb/quadrature_position_counter_core_tb.sv
// Self-checking testbench for the quadrature position counter core.
`timescale 1ns / 100ps

module quadrature_position_counter_core_tb;
    import qpc_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int SETTING_COUNT   = 7;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_MOSTLY
    } rx_pattern_t;

    logic                    aclk       = 1'b0;
    logic                    aresetn    = 1'b0;
    logic                    s_valid    = 1'b0;
    logic                    s_ready;
    logic                    s_load     = 1'b0;
    logic                    s_chan_a   = 1'b0;
    logic                    s_chan_b   = 1'b0;
    logic                    m_valid;
    logic                    m_ready    = 1'b0;
    logic signed [POS_W-1:0] m_position;
    logic                    cfg_valid  = 1'b0;
    logic                    cfg_ready;
    cfg_index_t              cfg_index  = CFG_STEP_SIZE;
    logic [POS_W-1:0]        cfg_data   = '0;

    // Decoder state as predicted from the accepted samples.
    phase_t                  model_phase;
    logic signed [POS_W-1:0] model_position;
    logic [STEP_W-1:0]       model_step;
    logic signed [POS_W-1:0] model_start;

    logic signed [POS_W-1:0] pending_positions[$];
    logic signed [POS_W-1:0] due_position;
    int                      error_count    = 0;
    int                      hold_request   = 0;
    int                      burst_left     = 0;
    bit                      sender_gapless = 1'b0;
    logic                    last_a         = 1'b0;
    logic                    last_b         = 1'b0;

    always #1 aclk = ~aclk;

    quadrature_position_counter_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_load     (s_load),
        .s_chan_a   (s_chan_a),
        .s_chan_b   (s_chan_b),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_position (m_position),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    function automatic phase_t channel_level(input logic a, input logic b);
        phase_t lv;
        case ({a, b})
            2'b00:   lv = PH_LOW;
            2'b10:   lv = PH_ATBF;
            2'b11:   lv = PH_HIGH;
            default: lv = PH_AFBT;
        endcase
        return lv;
    endfunction

    // Position of a level in the clockwise Gray order.
    function automatic int unsigned level_rank(input phase_t p);
        int unsigned rank;
        case (p)
            PH_ATBF: rank = 1;
            PH_HIGH: rank = 2;
            PH_AFBT: rank = 3;
            default: rank = 0;
        endcase
        return rank;
    endfunction

    function automatic logic [1:0] gray_levels(input int unsigned rank);
        logic [1:0] ab;
        case (rank % 4)
            0:       ab = 2'b00;
            1:       ab = 2'b10;
            2:       ab = 2'b11;
            default: ab = 2'b01;
        endcase
        return ab;
    endfunction

    function automatic logic signed [POS_W-1:0] add_saturating(
        input logic signed [POS_W-1:0] base,
        input logic signed [33:0]      delta
    );
        logic signed [33:0] sum;
        logic signed [POS_W-1:0] res;
        sum = base + delta;
        if (sum > 34'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (sum < -34'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = sum[POS_W-1:0];
        end
        return res;
    endfunction

    // Advances the predicted decoder by one sample and returns the position after it.
    function automatic logic signed [POS_W-1:0] advance_decoder(
        input logic ld,
        input logic a,
        input logic b
    );
        phase_t lv;
        logic signed [33:0] delta;
        lv    = channel_level(a, b);
        delta = $signed({18'd0, model_step});
        if (ld) begin
            model_position = model_start;
            model_phase    = lv;
        end else begin
            case (model_phase)
                PH_CW: begin
                    model_position = add_saturating(model_position, delta);
                    model_phase    = lv;
                end
                PH_CCW: begin
                    model_position = add_saturating(model_position, -delta);
                    model_phase    = lv;
                end
                PH_LOW, PH_ATBF, PH_HIGH, PH_AFBT: begin
                    // A diagonal jump matches neither neighbour and is ignored.
                    if (level_rank(lv) == (level_rank(model_phase) + 1) % 4) begin
                        model_phase = PH_CW;
                    end else if (level_rank(lv) == (level_rank(model_phase) + 3) % 4) begin
                        model_phase = PH_CCW;
                    end
                end
                default: begin
                    model_phase = lv;
                end
            endcase
        end
        return model_position;
    endfunction

    task automatic send_sample(input logic ld, input logic a, input logic b);
        int gap;
        if (!sender_gapless && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        @(negedge aclk);
        s_valid  <= 1'b1;
        s_load   <= ld;
        s_chan_a <= a;
        s_chan_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_positions.push_back(advance_decoder(ld, a, b));
        last_a = a;
        last_b = b;
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [POS_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_STEP_SIZE) begin
            model_step = data[STEP_W-1:0];
        end else begin
            model_start = data;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering samples and waits until every predicted position has been seen.
    task automatic settle_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Straight after reset: two clockwise edges with the reset step size.
    task automatic test_clockwise_count();
        send_sample(1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b0, 1'b1, 1'b1);
        send_sample(1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_counter_clockwise_count();
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b0);
    endtask

    // A change of the channels in the sample where a count lands is not counted.
    task automatic test_change_on_landing();
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b1, 1'b1);
        send_sample(1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_diagonal_jump();
        send_sample(1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_load_and_saturation();
        settle_block();
        write_register(CFG_STEP_SIZE, 32'hFFFF_FFFF);
        write_register(CFG_START_POSITION, 32'h7FFF_FFFF);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b0, 1'b1, 1'b1);
        send_sample(1'b0, 1'b1, 1'b1);
        settle_block();
        write_register(CFG_START_POSITION, 32'h8000_0000);
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b0, 1'b1, 1'b1);
        send_sample(1'b0, 1'b1, 1'b1);
        // A load while a count is pending drops the count.
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        settle_block();
        write_register(CFG_STEP_SIZE, 32'h0000_0000);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0);
    endtask

    // Mostly well-formed Gray walks with random holds and direction, with some
    // noise and loads mixed in.
    task automatic random_walk(input int items, input bit with_pressure);
        int unsigned rank;
        int          r;
        bit          dir_cw;
        logic [1:0]  ab;
        dir_cw = 1'($urandom_range(0, 1));
        for (int i = 0; i < items; i++) begin
            if (with_pressure && i == items / 2) begin
                hold_request   = 250;
                sender_gapless = 1'b1;
            end
            if (with_pressure && i == items / 2 + 60) begin
                sender_gapless = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_sample(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (r < 10) begin
                send_sample(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    dir_cw = !dir_cw;
                end
                rank = level_rank(channel_level(last_a, last_b));
                if ($urandom_range(0, 99) < 55) begin
                    rank = dir_cw ? (rank + 1) % 4 : (rank + 3) % 4;
                end
                ab = gray_levels(rank);
                send_sample(1'b0, ab[1], ab[0]);
            end
        end
    endtask

    task automatic test_random_settings();
        logic [STEP_W-1:0] step;
        logic [POS_W-1:0]  start;
        for (int s = 0; s < SETTING_COUNT; s++) begin
            case (s)
                0: begin step = STEP_SIZE_RESET; start = START_POSITION_RESET; end
                1: begin step = 16'd0;     start = $urandom; end
                2: begin step = 16'hFFFF;  start = 32'h7FFF_FFFF; end
                3: begin step = 16'hFFFF;  start = 32'h8000_0000; end
                4: begin step = 16'd1;     start = 32'h7FFF_0000; end
                5: begin step = 16'($urandom);  start = $urandom; end
                default: begin
                    step  = 16'($urandom_range(1, 64) << 10);
                    start = $urandom;
                end
            endcase
            settle_block();
            write_register(CFG_STEP_SIZE, {16'($urandom), step});
            write_register(CFG_START_POSITION, start);
            sender_gapless = (s % 3 == 1);
            random_walk(ITEMS_PER_PHASE, s == 4);
        end
        sender_gapless = 1'b0;
    endtask

    // Result receiver: stalls on a pattern of its own, or holds off for a
    // requested number of cycles.
    initial begin : result_receiver
        rx_pattern_t pattern;
        int          pattern_left;
        int          hold_len;
        int unsigned tick;
        pattern      = RX_ALWAYS;
        pattern_left = 0;
        tick         = 0;
        forever begin
            @(negedge aclk);
            if (hold_request != 0) begin
                hold_len     = hold_request;
                hold_request = 0;
                m_ready <= 1'b0;
                repeat (hold_len - 1) @(negedge aclk);
            end else begin
                if (pattern_left == 0) begin
                    pattern      = rx_pattern_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(20, 120);
                end
                pattern_left--;
                tick++;
                case (pattern)
                    RX_ALWAYS:      m_ready <= 1'b1;
                    RX_COIN:        m_ready <= 1'($urandom_range(0, 1));
                    RX_ONE_IN_FOUR: m_ready <= (tick % 4 == 0);
                    default:        m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_positions.size() == 0) begin
                $display("%0t: result transfer with no position expected, got %0d",
                         $time, m_position);
                error_count++;
            end else begin
                due_position = pending_positions.pop_front();
                if (m_position !== due_position) begin
                    $display("%0t: position mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                             $time, due_position, due_position, m_position, m_position);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("%0t: timeout with %0d positions outstanding", $time, pending_positions.size());
        $display("FAIL quadrature_position_counter_core");
        $finish;
    end

    initial begin
        model_phase    = PH_LOW;
        model_position = '0;
        model_step     = STEP_SIZE_RESET;
        model_start    = START_POSITION_RESET;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_clockwise_count();
        test_counter_clockwise_count();
        test_change_on_landing();
        test_diagonal_jump();
        test_load_and_saturation();
        test_random_settings();

        settle_block();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS quadrature_position_counter_core");
        end else begin
            $display("FAIL quadrature_position_counter_core");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/qpc_pkg.sv
hdl/qpc_phase.sv
hdl/quadrature_position_counter_core.sv
tb/quadrature_position_counter_core_tb.sv
